// File: hdl/e8x_pkg.sv
package e8x_pkg;

    localparam int ADDR_SPAN = 64;

    localparam int FLAG_C = 4;
    localparam int FLAG_V = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_S = 1;
    localparam int FLAG_Z = 0;

    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_LDI  = 4'd3,
        OP_BEQZ = 4'd4,
        OP_AND  = 4'd5,
        OP_OR   = 4'd6,
        OP_JR   = 4'd7,
        OP_SAL  = 4'd8,
        OP_SAR  = 4'd9,
        OP_LB   = 4'd10,
        OP_SB   = 4'd11
    } t_opcode;

    typedef struct packed {
        logic        valid_req;
        logic [3:0]  mode;
        logic [5:0]  dest_index;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [5:0]  immediate;
        logic [15:0] fetch_address;
    } t_exec_op;

    typedef struct packed {
        logic        reg_write;
        logic [5:0]  reg_index;
        logic [7:0]  reg_value;
        logic [4:0]  status_flags;
        logic        pc_write;
        logic [15:0] pc_target;
        logic        unknown_opcode;
    } t_exec_res;

endpackage

// File: hdl/e8x_ram.sv
module e8x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/e8x_alu.sv
module e8x_alu #(
    parameter int REG_COUNT = 64
) (
    input  e8x_pkg::t_exec_op  i_op,
    input  logic [7:0]         i_load_byte,
    input  logic [4:0]         i_flags,
    output e8x_pkg::t_exec_res o_res
);

    logic [7:0]        a;
    logic [7:0]        b;
    logic [7:0]        imm_s;
    logic [8:0]        sum;
    logic [15:0]       prod;
    logic signed [7:0] a_s;
    logic [2:0]        sar_amt;
    logic              wr;
    logic              jump;
    logic              unknown;
    logic [7:0]        val;
    logic [15:0]       target;
    logic [4:0]        flags;
    logic              v_bit;
    logic              in_range;

    always_comb begin
        a        = i_op.first_value;
        b        = i_op.second_value;
        a_s      = $signed(i_op.first_value);
        imm_s    = {{2{i_op.immediate[5]}}, i_op.immediate};
        sum      = {1'b0, a} + {1'b0, b};
        prod     = a * b;
        sar_amt  = (i_op.immediate >= 6'd8) ? 3'd7 : i_op.immediate[2:0];
        wr       = 1'b0;
        jump     = 1'b0;
        unknown  = 1'b0;
        val      = 8'd0;
        target   = 16'd0;
        flags    = i_flags;
        v_bit    = 1'b0;
        if (i_op.valid_req) begin
            unique case (e8x_pkg::t_opcode'(i_op.mode))
                e8x_pkg::OP_ADD: begin
                    val   = sum[7:0];
                    wr    = 1'b1;
                    v_bit = (~(a[7] ^ b[7])) & (a[7] ^ val[7]);
                    flags = {sum[8], v_bit, val[7], val[7] ^ v_bit, val == 8'd0};
                end
                e8x_pkg::OP_SUB: begin
                    val   = a - b;
                    wr    = 1'b1;
                    v_bit = (a[7] ^ b[7]) & (a[7] ^ val[7]);
                    flags = {i_flags[e8x_pkg::FLAG_C], v_bit, val[7], val[7] ^ v_bit,
                             val == 8'd0};
                end
                e8x_pkg::OP_MUL: begin
                    val = prod[7:0];
                    wr  = 1'b1;
                end
                e8x_pkg::OP_LDI: begin
                    val = imm_s;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_BEQZ: begin
                    if (a == 8'd0) begin
                        jump   = 1'b1;
                        target = i_op.fetch_address + 16'd1
                               + {{10{i_op.immediate[5]}}, i_op.immediate};
                    end
                end
                e8x_pkg::OP_AND: begin
                    val = a & b;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_OR: begin
                    val = a | b;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_JR: begin
                    jump   = 1'b1;
                    target = {a, b};
                end
                e8x_pkg::OP_SAL: begin
                    val = (i_op.immediate >= 6'd8) ? 8'd0 : (a << i_op.immediate[2:0]);
                    wr  = 1'b1;
                end
                e8x_pkg::OP_SAR: begin
                    val = 8'(a_s >>> sar_amt);
                    wr  = 1'b1;
                end
                e8x_pkg::OP_LB: begin
                    val = i_load_byte;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_SB: begin
                    wr = 1'b0;
                end
                default: begin
                    unknown = 1'b1;
                end
            endcase
            if (i_op.mode == e8x_pkg::OP_MUL || i_op.mode == e8x_pkg::OP_AND
                || i_op.mode == e8x_pkg::OP_OR || i_op.mode == e8x_pkg::OP_SAL
                || i_op.mode == e8x_pkg::OP_SAR) begin
                flags[e8x_pkg::FLAG_N] = val[7];
                flags[e8x_pkg::FLAG_Z] = (val == 8'd0);
            end
        end
        in_range = ({1'b0, i_op.dest_index} < 7'(REG_COUNT));
        wr       = wr & in_range;

        o_res.reg_write      = wr;
        o_res.reg_index      = wr ? i_op.dest_index : 6'd0;
        o_res.reg_value      = wr ? val : 8'd0;
        o_res.status_flags   = flags;
        o_res.pc_write       = jump;
        o_res.pc_target      = jump ? target : 16'd0;
        o_res.unknown_opcode = unknown;
    end

endmodule

// File: hdl/eight_bit_execute_stage.sv
// Execute stage of an 8-bit pipelined processor. It takes one instruction item in
// every cycle while o_stall is low; each result is held in the execute register and
// then in the output register. The data store sits in a single-port-per-direction
// RAM with a registered read: loads and stores address it on the cycle the item is
// accepted, so a load straight after a store to the same byte sees the stored value.
// One valid bit per addressable byte, cleared by reset, makes unwritten bytes read as
// zero, so no clearing pass is needed. The status flags are updated as each item
// leaves the execute register, in program order.
module eight_bit_execute_stage #(
    parameter int DATA_DEPTH = 64,
    parameter int REG_COUNT  = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_valid_req,
    input  logic [3:0]         i_mode,
    input  logic [5:0]         i_dest_index,
    input  logic signed [7:0]  i_first_value,
    input  logic signed [7:0]  i_second_value,
    input  logic [5:0]         i_immediate,
    input  logic [15:0]        i_fetch_address,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_reg_write,
    output logic [5:0]         o_reg_index,
    output logic signed [7:0]  o_reg_value,
    output logic [4:0]         o_status_flags,
    output logic               o_pc_write,
    output logic [15:0]        o_pc_target,
    output logic               o_unknown_opcode
);

    localparam int AW = $clog2(DATA_DEPTH);

    logic                           w_accept;
    logic                           w_advance;
    logic                           w_store;
    logic                           w_load;
    logic [AW-1:0]                  w_addr;
    logic [7:0]                     w_rdata;
    logic [7:0]                     w_load_byte;
    e8x_pkg::t_exec_res             w_res;

    logic                           r_s1_valid;
    logic                           n_s1_valid;
    e8x_pkg::t_exec_op              r_s1;
    logic                           r_o_valid;
    logic                           n_o_valid;
    e8x_pkg::t_exec_res             r_out;
    logic [4:0]                     r_flags;
    logic [e8x_pkg::ADDR_SPAN-1:0]  r_mem_valid;
    logic                           r_ld_valid;

    assign o_stall   = r_s1_valid & r_o_valid & i_stall;
    assign w_accept  = i_valid & ~o_stall;
    assign w_advance = r_s1_valid & (~r_o_valid | ~i_stall);
    assign w_store   = w_accept & i_valid_req & (i_mode == e8x_pkg::OP_SB);
    assign w_load    = w_accept & i_valid_req & (i_mode == e8x_pkg::OP_LB);
    assign w_addr    = AW'(i_immediate);

    always_comb begin
        n_s1_valid = w_accept | (r_s1_valid & ~w_advance);
        n_o_valid  = w_advance | (r_o_valid & i_stall);
    end

    e8x_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (w_addr),
        .i_wdata (i_first_value),
        .i_re    (w_load),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    assign w_load_byte = r_ld_valid ? w_rdata : 8'd0;

    e8x_alu #(
        .REG_COUNT (REG_COUNT)
    ) u_alu (
        .i_op        (r_s1),
        .i_load_byte (w_load_byte),
        .i_flags     (r_flags),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_o_valid   <= 1'b0;
            r_flags     <= 5'd0;
            r_mem_valid <= '0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_o_valid  <= n_o_valid;
            if (w_advance) begin
                r_flags <= w_res.status_flags;
            end
            if (w_store) begin
                r_mem_valid[i_immediate] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1.valid_req     <= i_valid_req;
            r_s1.mode          <= i_mode;
            r_s1.dest_index    <= i_dest_index;
            r_s1.first_value   <= i_first_value;
            r_s1.second_value  <= i_second_value;
            r_s1.immediate     <= i_immediate;
            r_s1.fetch_address <= i_fetch_address;
        end
        if (w_load) begin
            r_ld_valid <= r_mem_valid[i_immediate];
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_reg_write      = r_out.reg_write;
    assign o_reg_index      = r_out.reg_index;
    assign o_reg_value      = r_out.reg_value;
    assign o_status_flags   = r_out.status_flags;
    assign o_pc_write       = r_out.pc_write;
    assign o_pc_target      = r_out.pc_target;
    assign o_unknown_opcode = r_out.unknown_opcode;

endmodule

// File: tb/exec_checker.sv
`timescale 1ns / 100ps

module exec_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  logic                i_op_stall,
    input  e8x_pkg::t_exec_op   i_op,
    input  logic                i_res_valid,
    input  logic                i_res_stall,
    input  e8x_pkg::t_exec_res  i_res,
    output int                  o_failures,
    output int                  o_pending,
    output int                  o_checked
);

    logic [4:0]          flag_reg;
    logic [7:0]          byte_store [e8x_pkg::ADDR_SPAN];
    e8x_pkg::t_exec_res  expected_q [$];
    e8x_pkg::t_exec_res  want;
    int                  failures = 0;
    int                  checked  = 0;

    task automatic execute_op(input e8x_pkg::t_exec_op op, output e8x_pkg::t_exec_res res);
        logic [8:0]  sum;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  val;
        logic [7:0]  imm_s;
        logic [15:0] target;
        logic        wr;
        logic        jump;
        logic        unknown;
        logic        ovf;
        int          amt;
        a       = op.first_value;
        b       = op.second_value;
        imm_s   = {{2{op.immediate[5]}}, op.immediate};
        val     = 8'h00;
        target  = 16'h0000;
        wr      = 1'b0;
        jump    = 1'b0;
        unknown = 1'b0;
        if (op.valid_req) begin
            case (op.mode)
                e8x_pkg::OP_ADD: begin
                    sum = {1'b0, a} + {1'b0, b};
                    val = sum[7:0];
                    wr  = 1'b1;
                    ovf = ~(a[7] ^ b[7]) & (a[7] ^ val[7]);
                    flag_reg[e8x_pkg::FLAG_C] = sum[8];
                    flag_reg[e8x_pkg::FLAG_V] = ovf;
                    flag_reg[e8x_pkg::FLAG_N] = val[7];
                    flag_reg[e8x_pkg::FLAG_S] = val[7] ^ ovf;
                    flag_reg[e8x_pkg::FLAG_Z] = (val == 8'h00);
                end
                e8x_pkg::OP_SUB: begin
                    val = a - b;
                    wr  = 1'b1;
                    ovf = (a[7] ^ b[7]) & (a[7] ^ val[7]);
                    flag_reg[e8x_pkg::FLAG_V] = ovf;
                    flag_reg[e8x_pkg::FLAG_N] = val[7];
                    flag_reg[e8x_pkg::FLAG_S] = val[7] ^ ovf;
                    flag_reg[e8x_pkg::FLAG_Z] = (val == 8'h00);
                end
                e8x_pkg::OP_MUL, e8x_pkg::OP_AND, e8x_pkg::OP_OR, e8x_pkg::OP_SAL,
                e8x_pkg::OP_SAR: begin
                    wr = 1'b1;
                    case (op.mode)
                        e8x_pkg::OP_MUL: val = a * b;
                        e8x_pkg::OP_AND: val = a & b;
                        e8x_pkg::OP_OR:  val = a | b;
                        e8x_pkg::OP_SAL: begin
                            val = (op.immediate >= 8) ? 8'h00 : 8'(a << op.immediate);
                        end
                        default: begin
                            amt = (op.immediate >= 8) ? 7 : int'(op.immediate);
                            val = 8'($signed(a) >>> amt);
                        end
                    endcase
                    flag_reg[e8x_pkg::FLAG_N] = val[7];
                    flag_reg[e8x_pkg::FLAG_Z] = (val == 8'h00);
                end
                e8x_pkg::OP_LDI: begin
                    val = imm_s;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_BEQZ: begin
                    if (a == 8'h00) begin
                        jump   = 1'b1;
                        target = op.fetch_address + 16'd1 + {{8{imm_s[7]}}, imm_s};
                    end
                end
                e8x_pkg::OP_JR: begin
                    jump   = 1'b1;
                    target = {a, b};
                end
                e8x_pkg::OP_LB: begin
                    val = (op.immediate < e8x_pkg::ADDR_SPAN) ? byte_store[op.immediate]
                                                             : 8'h00;
                    wr  = 1'b1;
                end
                e8x_pkg::OP_SB: begin
                    if (op.immediate < e8x_pkg::ADDR_SPAN) begin
                        byte_store[op.immediate] = a;
                    end
                end
                default: begin
                    unknown = 1'b1;
                end
            endcase
        end
        res.reg_write      = wr;
        res.reg_index      = wr ? op.dest_index : 6'd0;
        res.reg_value      = wr ? val : 8'h00;
        res.status_flags   = flag_reg;
        res.pc_write       = jump;
        res.pc_target      = jump ? target : 16'h0000;
        res.unknown_opcode = unknown;
    endtask

    task automatic compare_field(input string name, input logic [15:0] exp_val,
                                 input logic [15:0] act_val);
        if (exp_val !== act_val) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flag_reg = 5'd0;
            foreach (byte_store[k]) begin
                byte_store[k] = 8'h00;
            end
            expected_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (expected_q.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, got %h", $time, i_res);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("reg_write", 16'(want.reg_write), 16'(i_res.reg_write));
                    compare_field("reg_index", 16'(want.reg_index), 16'(i_res.reg_index));
                    compare_field("reg_value", 16'(want.reg_value), 16'(i_res.reg_value));
                    compare_field("status_flags", 16'(want.status_flags),
                                  16'(i_res.status_flags));
                    compare_field("pc_write", 16'(want.pc_write), 16'(i_res.pc_write));
                    compare_field("pc_target", want.pc_target, i_res.pc_target);
                    compare_field("unknown_opcode", 16'(want.unknown_opcode),
                                  16'(i_res.unknown_opcode));
                    checked++;
                end
            end
            if (i_op_valid && !i_op_stall) begin
                execute_op(i_op, want);
                expected_q.push_back(want);
            end
        end
        o_failures <= failures;
        o_pending  <= expected_q.size();
        o_checked  <= checked;
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [3:0] OP_UNUSED_FIRST = 4'd12;
    localparam logic [3:0] OP_UNUSED_LAST  = 4'd15;
    localparam int         RANDOM_ITEMS    = 1850;
    localparam int         IDLE_LIMIT      = 2000;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    e8x_pkg::t_exec_op  cur_op  = '0;
    logic               o_stall;
    logic               o_valid;
    logic               o_reg_write;
    logic [5:0]         o_reg_index;
    logic [7:0]         o_reg_value;
    logic [4:0]         o_status_flags;
    logic               o_pc_write;
    logic [15:0]        o_pc_target;
    logic               o_unknown_opcode;

    int failures;
    int pending;
    int checked;
    int items_sent = 0;
    int idle_cycles = 0;
    int rx_cycles = 0;
    int stall_left = 0;
    logic rx_calm = 1'b0;
    logic tx_calm = 1'b0;

    always #6 i_clk = ~i_clk;

    eight_bit_execute_stage dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_valid_req      (cur_op.valid_req),
        .i_mode           (cur_op.mode),
        .i_dest_index     (cur_op.dest_index),
        .i_first_value    (cur_op.first_value),
        .i_second_value   (cur_op.second_value),
        .i_immediate      (cur_op.immediate),
        .i_fetch_address  (cur_op.fetch_address),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_reg_write      (o_reg_write),
        .o_reg_index      (o_reg_index),
        .o_reg_value      (o_reg_value),
        .o_status_flags   (o_status_flags),
        .o_pc_write       (o_pc_write),
        .o_pc_target      (o_pc_target),
        .o_unknown_opcode (o_unknown_opcode)
    );

    exec_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (i_valid),
        .i_op_stall  (o_stall),
        .i_op        (cur_op),
        .i_res_valid (o_valid),
        .i_res_stall (i_stall),
        .i_res       ({o_reg_write, o_reg_index, o_reg_value, o_status_flags,
                       o_pc_write, o_pc_target, o_unknown_opcode}),
        .o_failures  (failures),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 1;
        if (r < 85) return $urandom_range(2, 4);
        if (r < 97) return $urandom_range(5, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'h7F;
            3:       return 8'h80;
            4:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic e8x_pkg::t_exec_op make_op(input logic v, input logic [3:0] mode,
                                                  input logic [5:0] dest, input logic [7:0] a,
                                                  input logic [7:0] b, input logic [5:0] imm,
                                                  input logic [15:0] pc);
        e8x_pkg::t_exec_op op;
        op.valid_req     = v;
        op.mode          = mode;
        op.dest_index    = dest;
        op.first_value   = a;
        op.second_value  = b;
        op.immediate     = imm;
        op.fetch_address = pc;
        return op;
    endfunction

    function automatic e8x_pkg::t_exec_op rand_op();
        e8x_pkg::t_exec_op op;
        op.valid_req = ($urandom_range(0, 15) != 0);
        if ($urandom_range(0, 11) != 0) begin
            op.mode = 4'($urandom_range(e8x_pkg::OP_ADD, e8x_pkg::OP_SB));
        end else begin
            op.mode = 4'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
        end
        op.dest_index    = 6'($urandom());
        op.first_value   = pick_byte();
        op.second_value  = pick_byte();
        op.immediate     = 6'($urandom());
        op.fetch_address = 16'($urandom());
        if ((op.mode == e8x_pkg::OP_SAL || op.mode == e8x_pkg::OP_SAR)
            && $urandom_range(0, 1)) begin
            op.immediate = 6'($urandom_range(0, 9));
        end
        if ((op.mode == e8x_pkg::OP_LB || op.mode == e8x_pkg::OP_SB)
            && $urandom_range(0, 1)) begin
            op.immediate = 6'($urandom_range(0, 3));
        end
        if (op.mode == e8x_pkg::OP_BEQZ && $urandom_range(0, 1)) begin
            op.first_value = 8'h00;
        end
        return op;
    endfunction

    task automatic push_op(input e8x_pkg::t_exec_op op);
        int gap;
        cur_op  <= op;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        gap = (tx_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    always @(posedge i_clk) begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles % 256 == 255) begin
            rx_calm <= ($urandom_range(0, 3) == 0);
        end
        if (stall_left != 0) begin
            i_stall    <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!rx_calm && $urandom_range(0, 99) < 20) begin
            i_stall    <= 1'b1;
            stall_left <= pick_gap() - 1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        e8x_pkg::t_exec_op op;
        e8x_pkg::t_exec_op last;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_op(make_op(1'b1, e8x_pkg::OP_LB,   6'd0,  8'h00, 8'h00, 6'd63, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_ADD,  6'd63, 8'h7F, 8'h01, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_ADD,  6'd0,  8'hFF, 8'h01, 6'd0,  16'hFFFF));
        push_op(make_op(1'b1, e8x_pkg::OP_ADD,  6'd1,  8'h80, 8'h80, 6'd63, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SUB,  6'd2,  8'h80, 8'h01, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SUB,  6'd3,  8'h00, 8'h00, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_MUL,  6'd4,  8'h10, 8'h10, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_MUL,  6'd5,  8'hFF, 8'hFF, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_LDI,  6'd6,  8'h00, 8'h00, 6'd32, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_LDI,  6'd7,  8'h00, 8'h00, 6'd31, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_BEQZ, 6'd8,  8'h00, 8'h00, 6'd32, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_BEQZ, 6'd9,  8'h00, 8'h00, 6'd31, 16'hFFFF));
        push_op(make_op(1'b1, e8x_pkg::OP_BEQZ, 6'd10, 8'h01, 8'h00, 6'd1,  16'h1234));
        push_op(make_op(1'b1, e8x_pkg::OP_AND,  6'd11, 8'hF0, 8'h0F, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_OR,   6'd12, 8'h80, 8'h01, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_JR,   6'd13, 8'hFF, 8'hFF, 6'd0,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SAL,  6'd14, 8'h01, 8'h00, 6'd7,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SAL,  6'd15, 8'hFF, 8'h00, 6'd8,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SAR,  6'd16, 8'h80, 8'h00, 6'd63, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SAR,  6'd17, 8'h40, 8'h00, 6'd8,  16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_SB,   6'd18, 8'hA5, 8'h00, 6'd63, 16'h0000));
        push_op(make_op(1'b1, e8x_pkg::OP_LB,   6'd19, 8'h00, 8'h00, 6'd63, 16'h0000));
        push_op(make_op(1'b0, e8x_pkg::OP_ADD,  6'd20, 8'h7F, 8'h7F, 6'd0,  16'h0000));
        push_op(make_op(1'b1, OP_UNUSED_LAST,  6'd21, 8'h01, 8'h01, 6'd1, 16'h0001));
        push_op(make_op(1'b1, OP_UNUSED_FIRST, 6'd22, 8'h01, 8'h01, 6'd1, 16'h0001));
        drain_results();

        last = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0) begin
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            op = rand_op();
            if (last.valid_req && last.mode == e8x_pkg::OP_SB && $urandom_range(0, 1)) begin
                op.valid_req = 1'b1;
                op.mode      = e8x_pkg::OP_LB;
                op.immediate = last.immediate;
            end
            push_op(op);
            last = op;
        end
        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d items and compared %0d results: every opcode, bubbles,", items_sent,
                 checked);
        $display("unknown opcodes, saturating shifts and loads following stores.");
        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/e8x_pkg.sv
hdl/e8x_ram.sv
hdl/e8x_alu.sv
hdl/eight_bit_execute_stage.sv
tb/exec_checker.sv
tb/testbench.sv
